[design/pc_xt_ppi_keyboard_speaker_macros.svh]
// assertion macros for the pc xt ppi keyboard and speaker block
// used by the port checker; no other dependencies
`ifndef PC_XT_PPI_KEYBOARD_SPEAKER_MACROS_SVH
`define PC_XT_PPI_KEYBOARD_SPEAKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCXT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcxt check failed");

// next-cycle implication, disabled during reset
`define PCXT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcxt check failed");

`endif

[design/pcxt_pkg.sv]
// shared types, codes and constants of the pc xt ppi keyboard and speaker block
// no dependencies
package pcxt_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int RATE_W = 18;
  localparam int TONE_W = 21;
  localparam int HALF_W = RATE_W - 1;
  localparam int CNT_W  = 32;
  localparam int VOL_W  = 15;
  localparam int SMP_W  = 16;

  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [7:0]       KBD_RESET_CODE = 8'hAA;
  localparam logic [7:0]       CONTROL_RESET  = 8'd14;
  localparam logic [7:0]       SWITCH_RESET   = 8'h2E;
  localparam logic [VOL_W-1:0] VOLUME_RESET   = 15'd8192;
  localparam logic [7:0]       REFRESH_BIT    = 8'h10;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_TICK   = 3'd2,
    ACT_KEY    = 3'd3,
    ACT_SAMPLE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PORT_DATA    = 2'd0,
    PORT_CONTROL = 2'd1,
    PORT_SWITCH  = 2'd2,
    PORT_NONE    = 2'd3
  } port_t;

  typedef enum logic {
    REG_SWITCH = 1'b0,
    REG_VOLUME = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV1,
    S_DIV2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic force_wr;
    logic pop;
    logic clear;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_value;
    logic                    key_accepted;
    logic                    turbo_on;
    logic                    speaker_on;
    logic                    speaker_changed;
    logic                    irq;
    logic [7:0]              read_data;
  } result_t;

endpackage

[design/pcxt_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on pcxt_pkg
module pcxt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pcxt_pkg::CNT_W-1:0]     dividend,
  input  logic [pcxt_pkg::TONE_W-1:0]    divisor,
  output logic                           done,
  output logic [pcxt_pkg::CNT_W-1:0]     quotient
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [pcxt_pkg::DIV_CW-1:0]    cnt_r, cnt_nxt;
  logic [pcxt_pkg::TONE_W-1:0]    rem_r, rem_nxt;
  logic [pcxt_pkg::CNT_W-1:0]     quo_r, quo_nxt;
  logic [pcxt_pkg::TONE_W-1:0]    dvs_r, dvs_nxt;
  logic [pcxt_pkg::TONE_W:0]      trial;
  logic                           fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[pcxt_pkg::CNT_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? pcxt_pkg::TONE_W'(trial - {1'b0, dvs_r})
                     : pcxt_pkg::TONE_W'(trial);
      quo_nxt = {quo_r[pcxt_pkg::CNT_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pcxt_pkg::DIV_CW'(pcxt_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/pcxt_fifo.sv]
// scancode ring buffer with registered read of the head entry
// depends on pcxt_pkg
module pcxt_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcxt_pkg::fifo_cmd_t   cmd,
  input  logic [7:0]            wr_data,
  output pcxt_pkg::fifo_stat_t  stat,
  output logic [7:0]            rd_data
);

  localparam int AW = pcxt_pkg::FIFO_AW;

  logic [7:0]                    mem_r [pcxt_pkg::FIFO_DEPTH];
  logic [7:0]                    rd_r;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [pcxt_pkg::FIFO_CW-1:0]  count_r, count_nxt;
  logic [AW:0]                   tail_sum;
  logic [AW:0]                   last_sum;
  logic [AW-1:0]                 wr_idx;
  logic                          full;

  assign full = (count_r == pcxt_pkg::FIFO_CW'(pcxt_pkg::FIFO_DEPTH));

  // sums stay below twice the depth, so one compare and subtract wraps them
  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r);
  assign last_sum = (AW+1)'(head_r) + (AW+1)'(pcxt_pkg::FIFO_DEPTH - 1);

  always_comb begin
    if (cmd.force_wr) begin
      wr_idx = (last_sum >= (AW+1)'(pcxt_pkg::FIFO_DEPTH))
               ? AW'(last_sum - (AW+1)'(pcxt_pkg::FIFO_DEPTH)) : AW'(last_sum);
    end else begin
      wr_idx = (tail_sum >= (AW+1)'(pcxt_pkg::FIFO_DEPTH))
               ? AW'(tail_sum - (AW+1)'(pcxt_pkg::FIFO_DEPTH)) : AW'(tail_sum);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.pop) begin
      head_nxt  = (head_r == AW'(pcxt_pkg::FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.force_wr) begin
      mem_r[wr_idx] <= wr_data;
    end
    rd_r <= mem_r[head_r];
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = full;
  assign rd_data    = rd_r;

endmodule

[design/pc_xt_ppi_keyboard_speaker.sv]
// top level of the pc xt ppi keyboard port, control port and speaker sampler
// depends on pcxt_pkg, pcxt_div and pcxt_fifo
//
// usage
//   in_ channel: one word per bus access, timer tick, key event or sample
//   request; in_tuser carries the action, in_tdata the operands
//   out_ channel: exactly one result word per input word, in order
//   cfg_ port: apb-style, switch bits at 0x0 and tone volume at 0x4,
//   pready tied high; the user must see that it is written only while the
//   block is idle, as the block itself does not enforce this
//   reads, writes, ticks and key events pass through the exec and done
//   states to the output register; a sounding sample request runs two
//   passes of the shared divider (rate / tone, then counter / half period);
//   a silent one stops after the first pass or at once
//   in_tready is high only in the idle state, one word is worked at a time
// reset
//   synchronous, active low: all ports and flags return to their power-on
//   values, the scancode ring is emptied and the sample counter cleared
// stalls
//   the result sits in an output register; the next word is accepted while
//   it waits, and that word's result is held back until out_tready frees it
module pc_xt_ppi_keyboard_speaker (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: port_offset[1:0], write_data[9:2], key_code[17:10],
  // force_insert[18], sample_rate[36:19], tone_hz[57:37], zero fill above
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // in_tuser: action[2:0]
  input  logic [2:0]  in_tuser,
  // out_tdata: read_data[7:0], irq[8], speaker_changed[9], speaker_on[10],
  // turbo_on[11], key_accepted[12], sample_value[28:13], zero fill above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W  = pcxt_pkg::CNT_W;
  localparam int RATE_W = pcxt_pkg::RATE_W;
  localparam int TONE_W = pcxt_pkg::TONE_W;
  localparam int HALF_W = pcxt_pkg::HALF_W;
  localparam int VOL_W  = pcxt_pkg::VOL_W;
  localparam int SMP_W  = pcxt_pkg::SMP_W;

  pcxt_pkg::state_t state_r, state_nxt;

  // accepted word, held for the whole job
  pcxt_pkg::action_t   act_r;
  pcxt_pkg::port_t     off_r;
  logic [7:0]          wdat_r;
  logic [7:0]          key_r;
  logic                frc_r;
  logic [RATE_W-1:0]   rate_r;
  logic [TONE_W-1:0]   tone_r;

  // configuration registers
  logic [7:0]          switch_bits_r, switch_bits_nxt;
  logic [VOL_W-1:0]    tone_volume_r, tone_volume_nxt;

  // architectural state
  logic [7:0]          latch_r, latch_nxt;
  logic [7:0]          control_r, control_nxt;
  logic                pending_r, pending_nxt;
  logic                turbo_r, turbo_nxt;
  logic                spk_r, spk_nxt;
  logic [CNT_W-1:0]    counter_r, counter_nxt;

  // result staging and output register
  pcxt_pkg::result_t   res_r, res_nxt;
  pcxt_pkg::result_t   out_r;
  logic                out_valid_r, out_valid_nxt;

  // shared divider and scancode ring
  pcxt_pkg::div_ctl_t   div_ctl;
  logic [CNT_W-1:0]     div_dividend;
  logic [TONE_W-1:0]    div_divisor;
  logic [CNT_W-1:0]     div_quo;
  pcxt_pkg::fifo_cmd_t  fifo_cmd;
  pcxt_pkg::fifo_stat_t fifo_stat;
  logic [7:0]           fifo_rd;

  // sequencer strobes
  logic                 accept;
  logic                 out_load;
  logic                 sample_go;
  logic [HALF_W-1:0]    half;
  logic                 half_zero;
  logic [CNT_W-1:0]     counter_inc;
  logic                 cfg_wr;
  logic                 pend_new;
  logic [SMP_W-1:0]     vol_pos;

  assign sample_go   = spk_r && (tone_r != '0);
  assign half        = div_quo[HALF_W:1];
  assign half_zero   = (half == '0);
  assign counter_inc = counter_r + 1'b1;
  assign vol_pos     = {1'b0, tone_volume_r};

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcxt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = pcxt_pkg::S_EXEC;
      end
      pcxt_pkg::S_EXEC: begin
        if (act_r == pcxt_pkg::ACT_SAMPLE && sample_go) state_nxt = pcxt_pkg::S_DIV1;
        else                                              state_nxt = pcxt_pkg::S_DONE;
      end
      pcxt_pkg::S_DIV1: begin
        if (div_ctl.done) state_nxt = half_zero ? pcxt_pkg::S_DONE : pcxt_pkg::S_DIV2;
      end
      pcxt_pkg::S_DIV2: begin
        if (div_ctl.done) state_nxt = pcxt_pkg::S_DONE;
      end
      pcxt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = pcxt_pkg::S_IDLE;
      end
      default: state_nxt = pcxt_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = (state_r == pcxt_pkg::S_IDLE);
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      pcxt_pkg::S_EXEC: div_ctl.start = (act_r == pcxt_pkg::ACT_SAMPLE) && sample_go;
      pcxt_pkg::S_DIV1: div_ctl.start = div_ctl.done && !half_zero;
      pcxt_pkg::S_DONE: out_load      = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // first pass: rate / tone, second pass: incremented counter / half period
  assign div_dividend = (state_r == pcxt_pkg::S_EXEC) ? CNT_W'(rate_r) : counter_inc;
  assign div_divisor  = (state_r == pcxt_pkg::S_EXEC) ? tone_r : TONE_W'(half);

  pcxt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_ctl.start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_ctl.done),
    .quotient (div_quo)
  );

  pcxt_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fifo_cmd),
    .wr_data (key_r),
    .stat    (fifo_stat),
    .rd_data (fifo_rd)
  );

  // ------------------------------------------------------- datapath
  // keyboard reset request: already pending, or old control bits 7:6 clear and new ones not
  assign pend_new = pending_r || ((control_r[7:6] == 2'b00) && (wdat_r[7:6] != 2'b00));

  always_comb begin
    latch_nxt   = latch_r;
    control_nxt = control_r;
    pending_nxt = pending_r;
    turbo_nxt   = turbo_r;
    spk_nxt     = spk_r;
    counter_nxt = counter_r;
    res_nxt     = res_r;
    fifo_cmd    = '0;

    if (state_r == pcxt_pkg::S_EXEC) begin
      res_nxt = '0;
      unique case (act_r)
        pcxt_pkg::ACT_READ: begin
          unique case (off_r)
            pcxt_pkg::PORT_DATA: begin
              res_nxt.read_data = latch_r;
              if (pending_r) begin
                pending_nxt = 1'b0;
                latch_nxt   = '0;
              end
            end
            pcxt_pkg::PORT_CONTROL: begin
              // refresh bit toggles on every read
              control_nxt       = control_r ^ pcxt_pkg::REFRESH_BIT;
              res_nxt.read_data = control_r ^ pcxt_pkg::REFRESH_BIT;
            end
            pcxt_pkg::PORT_SWITCH: begin
              res_nxt.read_data = control_r[3] ? {4'b0, switch_bits_r[7:4]}
                                               : {4'b0, switch_bits_r[3:0]};
            end
            default: res_nxt.read_data = '0;
          endcase
        end
        pcxt_pkg::ACT_WRITE: begin
          if (off_r == pcxt_pkg::PORT_CONTROL) begin
            if ((wdat_r[1:0] == 2'b11) != spk_r) begin
              spk_nxt                 = (wdat_r[1:0] == 2'b11);
              counter_nxt             = '0;
              res_nxt.speaker_changed = 1'b1;
            end
            turbo_nxt   = wdat_r[2];
            pending_nxt = pend_new;
            if (pend_new && (latch_r != pcxt_pkg::KBD_RESET_CODE)) begin
              fifo_cmd.clear = 1'b1;
              latch_nxt      = pcxt_pkg::KBD_RESET_CODE;
              res_nxt.irq    = 1'b1;
            end
            control_nxt = wdat_r;
          end
        end
        pcxt_pkg::ACT_TICK: begin
          if (!fifo_stat.empty && !pending_r) begin
            latch_nxt    = fifo_rd;
            fifo_cmd.pop = 1'b1;
            res_nxt.irq  = 1'b1;
          end
        end
        pcxt_pkg::ACT_KEY: begin
          if (!fifo_stat.full) begin
            fifo_cmd.push        = 1'b1;
            res_nxt.key_accepted = 1'b1;
          end else if (frc_r) begin
            fifo_cmd.force_wr = 1'b1;
          end
        end
        default: ;
      endcase
      res_nxt.speaker_on = spk_nxt;
      res_nxt.turbo_on   = turbo_nxt;
    end else if (state_r == pcxt_pkg::S_DIV1) begin
      if (div_ctl.done && !half_zero) counter_nxt = counter_inc;
    end else if (state_r == pcxt_pkg::S_DIV2) begin
      // odd quotient gives the positive half of the wave
      if (div_ctl.done) begin
        res_nxt.sample_value = div_quo[0] ? vol_pos : SMP_W'(-vol_pos);
      end
    end
  end

  // ---------------------------------------------------- config port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    switch_bits_nxt = switch_bits_r;
    tone_volume_nxt = tone_volume_r;
    if (cfg_wr) begin
      unique case (pcxt_pkg::cfg_reg_t'(cfg_paddr[2]))
        pcxt_pkg::REG_SWITCH: switch_bits_nxt = cfg_pwdata[7:0];
        pcxt_pkg::REG_VOLUME: tone_volume_nxt = cfg_pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (pcxt_pkg::cfg_reg_t'(cfg_paddr[2]) == pcxt_pkg::REG_VOLUME)
                      ? 32'(tone_volume_r) : 32'(switch_bits_r);

  // ------------------------------------------------------ output word
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)                     out_valid_nxt = 1'b1;
    else if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_r);

  // ------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pcxt_pkg::S_IDLE;
      switch_bits_r <= pcxt_pkg::SWITCH_RESET;
      tone_volume_r <= pcxt_pkg::VOLUME_RESET;
      latch_r       <= '0;
      control_r     <= pcxt_pkg::CONTROL_RESET;
      pending_r     <= 1'b0;
      turbo_r       <= 1'b0;
      spk_r         <= 1'b0;
      counter_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      switch_bits_r <= switch_bits_nxt;
      tone_volume_r <= tone_volume_nxt;
      latch_r       <= latch_nxt;
      control_r     <= control_nxt;
      pending_r     <= pending_nxt;
      turbo_r       <= turbo_nxt;
      spk_r         <= spk_nxt;
      counter_r     <= counter_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= pcxt_pkg::action_t'(in_tuser);
      off_r  <= pcxt_pkg::port_t'(in_tdata[1:0]);
      wdat_r <= in_tdata[9:2];
      key_r  <= in_tdata[17:10];
      frc_r  <= in_tdata[18];
      rate_r <= in_tdata[36:19];
      tone_r <= in_tdata[57:37];
    end
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
  end

endmodule

[design/pcxt_checker.sv]
// port-level checker for the pc xt ppi keyboard and speaker block, bound to the top
// depends on pc_xt_ppi_keyboard_speaker_macros.svh
`include "pc_xt_ppi_keyboard_speaker_macros.svh"

module pcxt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // a stalled result word holds
  `PCXT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))

  // one word worked at a time: busy right after an accept
  `PCXT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a sounding sample needs the speaker enabled
  `PCXT_ASSERT_NOW(a_sample_needs_spk, clk, rst_n,
    out_tvalid && (out_tdata[28:13] != 16'd0), out_tdata[10])

  // irq and key acceptance come from different actions
  `PCXT_ASSERT_NOW(a_irq_key_excl, clk, rst_n, out_tvalid, !(out_tdata[8] && out_tdata[12]))

endmodule

bind pc_xt_ppi_keyboard_speaker pcxt_checker u_pcxt_checker (.*);

[tb/sv/tb_pc_xt_ppi_keyboard_speaker.sv]
// self-checking testbench for the pc xt ppi keyboard port, control port and speaker block
// needs pcxt_pkg and the block rtl; a built-in predictor checks every result word
// stimulus mixes directed cases, shaped random traffic, idling on both sides and a long stall
module tb_pc_xt_ppi_keyboard_speaker;
  import pcxt_pkg::*;

  // spare action codes: the block answers them with flags only
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int WATCHDOG_CYCLES = 2_000_000;
  localparam int PRINT_LIMIT     = 40;

  // one input word, unpacked
  typedef struct {
    logic [2:0]        action;
    logic [1:0]        port;
    logic [7:0]        wdata;
    logic [7:0]        key;
    logic              key_force;
    logic [RATE_W-1:0] rate;
    logic [TONE_W-1:0] tone;
  } ppi_word_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // in_tdata: port_offset, write_data, key_code, force_insert, sample_rate, tone_hz
  logic [63:0] in_tdata    = '0;
  // in_tuser: action
  logic [2:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // out_tdata: read_data, irq, speaker_changed, speaker_on, turbo_on, key_accepted,
  // sample_value
  logic [31:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pc_xt_ppi_keyboard_speaker DUT (.*);

  always #5 clk = ~clk;

  // predictor state: registers, ports, scancode ring and wave counter
  logic [7:0]          dip_switches;
  logic [VOL_W-1:0]    wave_amplitude;
  logic [7:0]          kbd_latch;
  logic [7:0]          ctrl_byte;
  logic                reset_pending;
  logic                turbo_now;
  logic                speaker_now;
  logic [7:0]          scan_ring [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  ring_head;
  logic [FIFO_CW-1:0]  ring_fill;
  logic [CNT_W-1:0]    wave_count;

  // results predicted but not yet seen, oldest first
  result_t awaited_results [$];

  int  mismatch_count  = 0;
  int  words_effective = 0;
  // idling on both sides; off gives stretches at full rate
  bit  idling_on         = 1'b1;
  // set by the stall test, taken and cleared by the receiver process
  bit  hold_off_request  = 1'b0;

  function automatic void ppi_power_on();
    dip_switches   = SWITCH_RESET;
    wave_amplitude = VOLUME_RESET;
    kbd_latch      = '0;
    ctrl_byte      = CONTROL_RESET;
    reset_pending  = 1'b0;
    turbo_now      = 1'b0;
    speaker_now    = 1'b0;
    ring_head      = '0;
    ring_fill      = '0;
    wave_count     = '0;
  endfunction

  // advance the predictor by one word and return the result it must give
  function automatic result_t ppi_apply(input ppi_word_t w);
    result_t            r;
    logic               spk_next;
    logic [31:0]        half;
    logic [31:0]        quot;
    logic [SMP_W-1:0]   amp;
    r = '0;
    case (w.action)
      ACT_READ: begin
        case (w.port)
          PORT_DATA: begin
            r.read_data = kbd_latch;
            // reading the latch ends a pending keyboard reset
            if (reset_pending) begin
              reset_pending = 1'b0;
              kbd_latch     = '0;
            end
          end
          PORT_CONTROL: begin
            ctrl_byte   = ctrl_byte ^ REFRESH_BIT;
            r.read_data = ctrl_byte;
          end
          PORT_SWITCH:
            r.read_data = ctrl_byte[3] ? {4'h0, dip_switches[7:4]} : {4'h0, dip_switches[3:0]};
          default: r.read_data = '0;
        endcase
      end
      ACT_WRITE: begin
        if (w.port == PORT_CONTROL) begin
          spk_next = &w.wdata[1:0];
          if (spk_next != speaker_now) begin
            speaker_now       = spk_next;
            wave_count        = '0;
            r.speaker_changed = 1'b1;
          end
          turbo_now = w.wdata[2];
          // a rising request on bits 7:6 arms the keyboard reset
          if (ctrl_byte[7:6] == 2'b00 && w.wdata[7:6] != 2'b00)
            reset_pending = 1'b1;
          if (reset_pending && kbd_latch != KBD_RESET_CODE) begin
            ring_fill = '0;
            kbd_latch = KBD_RESET_CODE;
            r.irq     = 1'b1;
          end
          ctrl_byte = w.wdata;
        end
      end
      ACT_TICK: begin
        if (ring_fill != 0 && !reset_pending) begin
          kbd_latch = scan_ring[ring_head];
          ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
          r.irq     = 1'b1;
        end
      end
      ACT_KEY: begin
        if (ring_fill < FIFO_DEPTH) begin
          scan_ring[ring_head + ring_fill[FIFO_AW-1:0]] = w.key;
          ring_fill      = ring_fill + 1'b1;
          r.key_accepted = 1'b1;
        end else if (w.key_force) begin
          // full ring: the newest entry is replaced
          scan_ring[ring_head - 1'b1] = w.key;
        end
      end
      ACT_SAMPLE: begin
        if (speaker_now && w.tone != 0) begin
          half = (32'(w.rate) / 32'(w.tone)) >> 1;
          if (half != 0) begin
            wave_count     = wave_count + 1'b1;
            quot           = wave_count / half;
            amp            = {1'b0, wave_amplitude};
            r.sample_value = quot[0] ? amp : -amp;
          end
        end
      end
      default: ;
    endcase
    r.speaker_on = speaker_now;
    r.turbo_on   = turbo_now;
    return r;
  endfunction

  // gap before a word or length of a stall: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // fully random word, spare actions now and then
  function automatic ppi_word_t any_word();
    ppi_word_t w;
    if ($urandom_range(0, 19) == 0) w.action = $urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST);
    else                            w.action = $urandom_range(ACT_READ, ACT_SAMPLE);
    w.port      = $urandom_range(0, 3);
    w.wdata     = $urandom_range(0, 255);
    w.key       = $urandom_range(0, 255);
    w.key_force = $urandom_range(0, 1);
    w.rate      = $urandom_range(1, 262143);
    w.tone      = $urandom_range(0, 1193182);
    return w;
  endfunction

  // sample request, mostly with a short half period so the wave flips often
  function automatic ppi_word_t tone_word();
    ppi_word_t w;
    w        = any_word();
    w.action = ACT_SAMPLE;
    if ($urandom_range(0, 4) != 0) begin
      w.tone = $urandom_range(1, 3000);
      w.rate = w.tone * $urandom_range(2, 60);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
  endtask

  // offer one word and wait for the handshake; valid stays high for a back-to-back word
  task automatic send_word(input ppi_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.action;
    in_tdata  <= {6'd0, w.tone, w.rate, w.key_force, w.key, w.wdata, w.port};
    do @(posedge clk); while (!in_tready);
    awaited_results.push_back(ppi_apply(w));
    // ignored words do not count towards the traffic target
    if (w.action <= ACT_SAMPLE && !(w.action == ACT_WRITE && w.port != PORT_CONTROL))
      words_effective++;
  endtask

  task automatic send_op(input logic [2:0] act, input logic [1:0] port, input logic [7:0] data);
    ppi_word_t w;
    w           = any_word();
    w.action    = act;
    w.port      = port;
    w.wdata     = data;
    w.key       = data;
    w.key_force = 1'b0;
    send_word(w);
  endtask

  task automatic send_tone(input logic [RATE_W-1:0] rate, input logic [TONE_W-1:0] tone);
    ppi_word_t w;
    w        = any_word();
    w.action = ACT_SAMPLE;
    w.rate   = rate;
    w.tone   = tone;
    send_word(w);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // apb write: setup then access phase, only while the block is idle
  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_SWITCH) dip_switches   = value[7:0];
    else                   wave_amplitude = value[VOL_W-1:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- directed tests

  // unused port, switch nibble with control bit 3 set, refresh toggling both ways
  task automatic test_port_reads();
    send_op(ACT_READ, PORT_NONE, 8'h00);
    send_op(ACT_READ, PORT_SWITCH, 8'h00);
    send_op(ACT_READ, PORT_CONTROL, 8'h00);
    send_op(ACT_READ, PORT_CONTROL, 8'h00);
  endtask

  // speaker on with turbo, audible and silent samples, speaker off again
  task automatic test_speaker_samples();
    send_op(ACT_WRITE, PORT_CONTROL, 8'h07);
    send_op(ACT_READ, PORT_SWITCH, 8'h00);   // bit 3 clear: low nibble
    send_tone(18'd44100, 21'd1000);
    send_tone(18'd262143, 21'd1);            // longest half period
    send_tone(18'd1, 21'd1193182);           // half period rounds to zero
    send_tone(18'd8000, 21'd0);              // no tone
    send_op(ACT_WRITE, PORT_CONTROL, 8'h04); // speaker off, turbo stays
    send_tone(18'd44100, 21'd1000);          // silent while off
  endtask

  // one scancode through the latch, then a tick on an empty ring
  task automatic test_key_queue();
    send_op(ACT_KEY, PORT_DATA, 8'hFF);
    send_op(ACT_TICK, PORT_DATA, 8'h00);
    send_op(ACT_READ, PORT_DATA, 8'h00);
    send_op(ACT_TICK, PORT_DATA, 8'h00);
  endtask

  // fill the ring, then a dropped key and a forced overwrite of the newest entry
  task automatic test_queue_overflow();
    ppi_word_t w;
    for (int i = 0; i < FIFO_DEPTH; i++)
      send_op(ACT_KEY, PORT_DATA, 8'(i * 17));
    send_op(ACT_KEY, PORT_DATA, 8'h3C);
    w           = any_word();
    w.action    = ACT_KEY;
    w.key       = 8'h5A;
    w.key_force = 1'b1;
    send_word(w);
  endtask

  // keyboard reset: latch forced, ring emptied, ticks held until the latch is read
  task automatic test_keyboard_reset();
    send_op(ACT_WRITE, PORT_CONTROL, 8'hC3);
    send_op(ACT_WRITE, PORT_CONTROL, 8'h80);  // latch already forced: no second pulse
    send_op(ACT_TICK, PORT_DATA, 8'h00);
    send_op(ACT_READ, PORT_DATA, 8'h00);
    send_op(ACT_READ, PORT_DATA, 8'h00);
    send_op(ACT_TICK, PORT_DATA, 8'h00);
    send_op(ACT_WRITE, PORT_DATA, 8'hFF);     // only the control port takes writes
    send_op(ACT_WRITE, PORT_NONE, 8'hFF);
    send_op(ACT_WRITE, PORT_CONTROL, 8'h00);
    send_op(ACT_SPARE_LAST, PORT_NONE, 8'hFF);
  endtask

  // ---------------------------------------------------------------- random traffic

  // well-formed sequences with random content, plus some noise
  task automatic run_mixed_traffic(input int words);
    ppi_word_t w;
    int        stop_at;
    stop_at = words_effective + words;
    while (words_effective < stop_at) begin
      if ($urandom_range(0, 9) == 0) idling_on = !idling_on;
      case ($urandom_range(0, 9))
        0, 1: begin
          // scancode burst, long ones run the ring full
          repeat ($urandom_range(1, 20)) begin
            w           = any_word();
            w.action    = ACT_KEY;
            w.key_force = ($urandom_range(0, 3) == 0);
            send_word(w);
          end
        end
        2, 3: begin
          // move scancodes into the latch and read them back
          repeat ($urandom_range(1, 12)) begin
            w        = any_word();
            w.action = ACT_TICK;
            send_word(w);
            w        = any_word();
            w.action = ACT_READ;
            w.port   = PORT_DATA;
            send_word(w);
          end
        end
        4, 5: begin
          // speaker on, then a run of samples
          w          = any_word();
          w.action   = ACT_WRITE;
          w.port     = PORT_CONTROL;
          w.wdata[1:0] = 2'b11;
          if ($urandom_range(0, 3) != 0) w.wdata[7:6] = 2'b00;
          send_word(w);
          repeat ($urandom_range(1, 16)) send_word(tone_word());
        end
        6: begin
          // keyboard reset: arm, blocked tick, latch read-out
          w            = any_word();
          w.action     = ACT_WRITE;
          w.port       = PORT_CONTROL;
          w.wdata[7:6] = 2'b00;
          send_word(w);
          w.wdata[7:6] = 2'($urandom_range(1, 3));
          send_word(w);
          w        = any_word();
          w.action = ACT_TICK;
          send_word(w);
          repeat ($urandom_range(1, 2)) begin
            w        = any_word();
            w.action = ACT_READ;
            w.port   = PORT_DATA;
            send_word(w);
          end
        end
        7: begin
          // port accesses of any offset
          w        = any_word();
          w.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
          send_word(w);
        end
        default: send_word(any_word());
      endcase
    end
  endtask

  // several register settings, the extremes first
  task automatic test_config_sweep();
    logic [7:0]       sw;
    logic [VOL_W-1:0] vol;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin sw = 8'h00; vol = '0; end
        1:       begin sw = 8'hFF; vol = '1; end
        default: begin sw = $urandom_range(0, 255); vol = $urandom_range(0, 32767); end
      endcase
      wait_idle();
      cfg_write(REG_SWITCH, 32'(sw));
      cfg_write(REG_VOLUME, 32'(vol));
      run_mixed_traffic(400);
    end
  endtask

  // receiver holds off for a long stretch while words are offered at full rate until the block stalls
  task automatic test_output_backpressure();
    idling_on        = 1'b0;
    hold_off_request = 1'b1;
    repeat (40) send_word(any_word());
    idling_on        = 1'b1;
  endtask

  // ---------------------------------------------------------------- processes

  // receiver side: random ready pattern, or the long hold-off when asked
  initial begin : result_pacing
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!idling_on || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4))
          @(posedge clk);
      end
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result word with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        got  = out_tdata[28:0];
        compare_field("read_data", got.read_data, want.read_data);
        compare_field("irq", got.irq, want.irq);
        compare_field("speaker_changed", got.speaker_changed, want.speaker_changed);
        compare_field("speaker_on", got.speaker_on, want.speaker_on);
        compare_field("turbo_on", got.turbo_on, want.turbo_on);
        compare_field("key_accepted", got.key_accepted, want.key_accepted);
        compare_field("sample_value", got.sample_value, want.sample_value);
      end
    end
  end

  // test sequence
  initial begin
    ppi_power_on();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_port_reads();
    test_speaker_samples();
    test_key_queue();
    test_queue_overflow();
    test_keyboard_reset();
    test_output_backpressure();
    test_config_sweep();
    // drain, then allow for the slowest sample request
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin : run_limit
    #(WATCHDOG_CYCLES * 10);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[pc_xt_ppi_keyboard_speaker.f]
+incdir+design
design/pcxt_pkg.sv
design/pcxt_div.sv
design/pcxt_fifo.sv
design/pc_xt_ppi_keyboard_speaker.sv
design/pcxt_checker.sv
tb/sv/tb_pc_xt_ppi_keyboard_speaker.sv
